>>> sv/dtw_pkg.sv
`timescale 1ns / 1ps
package dtw_pkg;

  // fixed field widths
  localparam int SAMPLE_W = 20;
  localparam int COST_W   = 40;
  localparam int STEPS_W  = 10;
  localparam int SCORE_W  = 48;
  localparam int SUM_W    = 48;
  localparam int ROOT_W   = 24;
  localparam int DIV_W    = 40;
  localparam int DVSR_W   = 10;
  localparam int CFG_W    = 10;
  localparam int DIMS_W   = 5;

  localparam logic [STEPS_W-1:0] STEPS_MAX   = 10'd1023;
  localparam logic [COST_W-1:0]  FAR_PENALTY = 40'd256000000;
  localparam logic [DVSR_W-1:0]  PENALTY_DIV = 10'd20;
  localparam logic [DIMS_W-1:0]  DIMS_RESET  = 5'd13;
  localparam logic [CFG_W-1:0]   GAP_RESET   = 10'd20;

  // reciprocal of 5 with 34 fraction bits, for gap*gap*256/20 as gap*gap*64/5
  localparam logic [31:0] PENALTY_RECIP = 32'hCCCC_CCCD;

  // action codes
  localparam logic [2:0] ACT_CLEAR   = 3'd0;
  localparam logic [2:0] ACT_MEAN    = 3'd1;
  localparam logic [2:0] ACT_REF     = 3'd2;
  localparam logic [2:0] ACT_TEST    = 3'd3;
  localparam logic [2:0] ACT_COMPUTE = 3'd4;

  // status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_OVER  = 2'd2;

  // register indexes
  localparam logic REG_VECTOR_DIMS = 1'b0;
  localparam logic REG_GAP_LIMIT   = 1'b1;

  // divider operand selection
  localparam logic [1:0] DIV_REF   = 2'd0;
  localparam logic [1:0] DIV_TEST  = 2'd1;
  localparam logic [1:0] DIV_SCORE = 2'd2;

  typedef struct packed {
    logic [2:0]                 action;
    logic signed [SAMPLE_W-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic [COST_W-1:0]  total_cost;
    logic [STEPS_W-1:0] path_length;
    logic [SCORE_W-1:0] match_score;
    logic [1:0]         status;
  } result_t;

  typedef struct packed {
    logic       load_en;
    logic       div_go;
    logic [1:0] div_sel;
    logic       gap_calc;
    logic       gapsq_calc;
    logic       row_init;
    logic       col_init;
    logic       elem_mul;
    logic       elem_acc;
    logic       sqrt_go;
    logic       cell_upd;
    logic       res_ok;
    logic       res_bad;
  } cmd_t;

  typedef struct packed {
    logic       div_done;
    logic       sqrt_done;
    logic [1:0] code;
    logic       last_elem;
    logic       last_col;
    logic       last_row;
  } stat_t;

endpackage

>>> sv/dtw_div.sv
`timescale 1ns / 1ps
module dtw_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [dtw_pkg::DIV_W-1:0]   dividend,
  input  logic [dtw_pkg::DVSR_W-1:0]  divisor,
  output logic                        done,
  output logic [dtw_pkg::DIV_W-1:0]   quotient,
  output logic [dtw_pkg::DVSR_W-1:0]  remainder
);
  localparam int CNT_W = $clog2(dtw_pkg::DIV_W + 1);

  logic [dtw_pkg::DIV_W-1:0]  quo;
  logic [dtw_pkg::DVSR_W:0]   rem;
  logic [dtw_pkg::DVSR_W-1:0] dvsr;
  logic [CNT_W-1:0]           cnt;
  logic                       running;
  logic [dtw_pkg::DVSR_W:0]   trial;
  logic                       fits;

  // one quotient bit per cycle, restoring
  assign trial = {rem[dtw_pkg::DVSR_W-1:0], quo[dtw_pkg::DIV_W-1]};
  assign fits  = trial >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(dtw_pkg::DIV_W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= dividend;
      rem  <= '0;
      dvsr <= divisor;
    end else if (running) begin
      rem <= fits ? trial - {1'b0, dvsr} : trial;
      quo <= {quo[dtw_pkg::DIV_W-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign remainder = rem[dtw_pkg::DVSR_W-1:0];
endmodule

>>> sv/dtw_isqrt.sv
`timescale 1ns / 1ps
module dtw_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [dtw_pkg::SUM_W-1:0]   value,
  output logic                        done,
  output logic [dtw_pkg::ROOT_W-1:0]  root
);
  localparam int ITER  = dtw_pkg::SUM_W / 2;
  localparam int CNT_W = $clog2(ITER + 1);

  logic [dtw_pkg::SUM_W-1:0] rad;
  logic [dtw_pkg::SUM_W-1:0] res;
  logic [dtw_pkg::SUM_W-1:0] bitv;
  logic [dtw_pkg::SUM_W-1:0] trial;
  logic [CNT_W-1:0]          cnt;
  logic                      running;

  assign trial = res + bitv;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(ITER);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // two radicand bits per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= value;
      res  <= '0;
      bitv <= {2'b01, {(dtw_pkg::SUM_W-2){1'b0}}};
    end else if (running) begin
      if (rad >= trial) begin
        rad <= rad - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

  assign root = res[dtw_pkg::ROOT_W-1:0];
endmodule

>>> sv/dtw_ctrl.sv
`timescale 1ns / 1ps
module dtw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [2:0]        action,
  input  dtw_pkg::stat_t    stat,
  output dtw_pkg::cmd_t     cmd,
  output logic              busy,
  output logic              result_valid
);
  typedef enum logic [4:0] {
    ST_IDLE, ST_DIVR, ST_DIVR_W, ST_DIVC, ST_DIVC_W, ST_CHECK, ST_GAPSQ,
    ST_ROWSET, ST_COLSET, ST_RD, ST_MUL, ST_ACC, ST_SQ, ST_SQ_W, ST_UPD,
    ST_SDIV, ST_SDIV_W, ST_FIN
  } state_t;

  state_t state;

  assign busy = (state != ST_IDLE);

  // sequencer state and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        ST_IDLE:   if (start && action == dtw_pkg::ACT_COMPUTE) state <= ST_DIVR;
        ST_DIVR:   state <= ST_DIVR_W;
        ST_DIVR_W: if (stat.div_done) state <= ST_DIVC;
        ST_DIVC:   state <= ST_DIVC_W;
        ST_DIVC_W: if (stat.div_done) state <= ST_CHECK;
        ST_CHECK: begin
          if (stat.code != dtw_pkg::STAT_OK) begin
            state        <= ST_IDLE;
            result_valid <= 1'b1;
          end else begin
            state <= ST_GAPSQ;
          end
        end
        ST_GAPSQ:  state <= ST_ROWSET;
        ST_ROWSET: state <= ST_COLSET;
        ST_COLSET: state <= ST_RD;
        ST_RD:     state <= ST_MUL;
        ST_MUL:    state <= ST_ACC;
        ST_ACC:    state <= stat.last_elem ? ST_SQ : ST_RD;
        ST_SQ:     state <= ST_SQ_W;
        ST_SQ_W:   if (stat.sqrt_done) state <= ST_UPD;
        ST_UPD: begin
          if (!stat.last_col) state <= ST_RD;
          else if (!stat.last_row) state <= ST_COLSET;
          else state <= ST_SDIV;
        end
        ST_SDIV:   state <= ST_SDIV_W;
        ST_SDIV_W: if (stat.div_done) state <= ST_FIN;
        ST_FIN: begin
          state        <= ST_IDLE;
          result_valid <= 1'b1;
        end
        default:   state <= ST_IDLE;
      endcase
    end
  end

  // datapath commands
  always_comb begin
    cmd            = '0;
    cmd.load_en    = (state == ST_IDLE) && start;
    cmd.gap_calc   = (state == ST_CHECK);
    cmd.gapsq_calc = (state == ST_GAPSQ);
    cmd.row_init   = (state == ST_ROWSET);
    cmd.col_init   = (state == ST_COLSET);
    cmd.elem_mul   = (state == ST_MUL);
    cmd.elem_acc   = (state == ST_ACC);
    cmd.sqrt_go    = (state == ST_SQ);
    cmd.cell_upd   = (state == ST_UPD);
    cmd.res_ok     = (state == ST_FIN);
    cmd.res_bad    = (state == ST_CHECK) && (stat.code != dtw_pkg::STAT_OK);
    case (state)
      ST_DIVR: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = dtw_pkg::DIV_REF;
      end
      ST_DIVC: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = dtw_pkg::DIV_TEST;
      end
      ST_SDIV: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = dtw_pkg::DIV_SCORE;
      end
      default: cmd.div_go = 1'b0;
    endcase
  end
endmodule

>>> sv/dtw_dp.sv
`timescale 1ns / 1ps
module dtw_dp #(
  parameter int MAX_FRAMES = 512,
  parameter int MAX_DIMS   = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  dtw_pkg::in_item_t          item,
  input  dtw_pkg::cmd_t              cmd,
  output dtw_pkg::stat_t             stat,
  input  logic                       cfg_valid,
  input  logic                       cfg_index,
  input  logic [dtw_pkg::CFG_W-1:0]  cfg_data,
  output dtw_pkg::result_t           result
);
  localparam int STORE_DEPTH = MAX_FRAMES * MAX_DIMS;
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int CNT_W  = $clog2(STORE_DEPTH + 2);
  localparam int DIM_W  = $clog2(MAX_DIMS + 1);
  localparam int MIDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int FR_W   = $clog2(MAX_FRAMES + 1);
  localparam int CMP_W  = (FR_W > dtw_pkg::CFG_W) ? FR_W : dtw_pkg::CFG_W;
  localparam int COST_W = dtw_pkg::COST_W;
  localparam int STEPS_W = dtw_pkg::STEPS_W;
  localparam int SAMPLE_W = dtw_pkg::SAMPLE_W;

  // configuration registers
  logic [dtw_pkg::DIMS_W-1:0] dims;
  logic [dtw_pkg::CFG_W-1:0]  gap_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims      <= dtw_pkg::DIMS_RESET;
      gap_limit <= dtw_pkg::GAP_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        dtw_pkg::REG_VECTOR_DIMS: dims <= cfg_data[dtw_pkg::DIMS_W-1:0];
        dtw_pkg::REG_GAP_LIMIT:   gap_limit <= cfg_data;
        default:                  gap_limit <= gap_limit;
      endcase
    end
  end

  // effective dimension
  logic [DIM_W-1:0] d_eff;
  always_comb begin
    if (dims == '0) d_eff = DIM_W'(1);
    else if (32'(dims) > MAX_DIMS) d_eff = DIM_W'(MAX_DIMS);
    else d_eff = DIM_W'(dims);
  end

  // load counters
  logic [DIM_W-1:0] mean_count;
  logic [CNT_W-1:0] ref_count;
  logic [CNT_W-1:0] test_count;
  logic             ld_mean, ld_ref, ld_test;

  assign ld_mean = cmd.load_en && item.action == dtw_pkg::ACT_MEAN;
  assign ld_ref  = cmd.load_en && item.action == dtw_pkg::ACT_REF;
  assign ld_test = cmd.load_en && item.action == dtw_pkg::ACT_TEST;

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_count <= '0;
      ref_count  <= '0;
      test_count <= '0;
    end else if (cmd.load_en && item.action == dtw_pkg::ACT_CLEAR) begin
      mean_count <= '0;
      ref_count  <= '0;
      test_count <= '0;
    end else begin
      if (ld_mean && mean_count < DIM_W'(MAX_DIMS)) mean_count <= mean_count + 1'b1;
      if (ld_ref && ref_count < CNT_W'(STORE_DEPTH + 1)) ref_count <= ref_count + 1'b1;
      if (ld_test && test_count < CNT_W'(STORE_DEPTH + 1)) test_count <= test_count + 1'b1;
    end
  end

  // element stores
  logic [SAMPLE_W-1:0] mean_store [MAX_DIMS];
  logic [SAMPLE_W-1:0] ref_store  [STORE_DEPTH];
  logic [SAMPLE_W-1:0] test_store [STORE_DEPTH];
  logic [SAMPLE_W-1:0] mean_rd, ref_rd, test_rd;

  logic [DIM_W-1:0] k;
  logic [CNT_W-1:0] ref_base, test_base;
  logic [CNT_W-1:0] ref_sum, test_sum;

  assign ref_sum  = ref_base + CNT_W'(k);
  assign test_sum = test_base + CNT_W'(k);

  always_ff @(posedge clk) begin
    if (ld_mean && mean_count < DIM_W'(MAX_DIMS))
      mean_store[mean_count[MIDX_W-1:0]] <= item.sample_value;
    mean_rd <= mean_store[k[MIDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ld_ref && ref_count < CNT_W'(STORE_DEPTH))
      ref_store[ref_count[ADDR_W-1:0]] <= item.sample_value;
    ref_rd <= ref_store[ref_sum[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ld_test && test_count < CNT_W'(STORE_DEPTH))
      test_store[test_count[ADDR_W-1:0]] <= item.sample_value;
    test_rd <= test_store[test_sum[ADDR_W-1:0]];
  end

  // shared divider
  logic [dtw_pkg::DIV_W-1:0]  dvd, quo;
  logic [dtw_pkg::DVSR_W-1:0] dvs, rem;
  logic                       div_done;
  logic [1:0]                 div_sel;

  logic [CNT_W-1:0]   rows, cols;
  logic               rows_rem, cols_rem;
  logic [FR_W-1:0]    gap;
  logic [2*FR_W-1:0]  gapsq;
  logic [COST_W-1:0]  total, first;
  logic [STEPS_W-1:0] steps;
  logic [COST_W-1:0]  s_val;
  logic [COST_W-1:0]  score_quo;
  logic [dtw_pkg::DIV_W-1:0] gap_quo;

  assign s_val = (CMP_W'(gap) >= CMP_W'(gap_limit)) ? dtw_pkg::FAR_PENALTY
                                                    : total - first;

  always_comb begin
    case (cmd.div_sel)
      dtw_pkg::DIV_REF: begin
        dvd = dtw_pkg::DIV_W'(ref_count);
        dvs = dtw_pkg::DVSR_W'(d_eff);
      end
      dtw_pkg::DIV_TEST: begin
        dvd = dtw_pkg::DIV_W'(test_count);
        dvs = dtw_pkg::DVSR_W'(d_eff);
      end
      default: begin
        dvd = s_val;
        dvs = steps - 1'b1;
      end
    endcase
  end

  dtw_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_go),
    .dividend  (dvd),
    .divisor   (dvs),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_go) div_sel <= cmd.div_sel;
    if (div_done) begin
      case (div_sel)
        dtw_pkg::DIV_REF: begin
          rows     <= quo[CNT_W-1:0];
          rows_rem <= rem != '0;
        end
        dtw_pkg::DIV_TEST: begin
          cols     <= quo[CNT_W-1:0];
          cols_rem <= rem != '0;
        end
        default: score_quo <= (steps > STEPS_W'(1)) ? quo : '0;
      endcase
    end
  end

  // load checks
  logic over, empty;
  assign over = ref_count > CNT_W'(STORE_DEPTH) || test_count > CNT_W'(STORE_DEPTH) ||
                rows > CNT_W'(MAX_FRAMES) || cols > CNT_W'(MAX_FRAMES);
  assign empty = ref_count == '0 || test_count == '0 || rows_rem || cols_rem ||
                 mean_count < d_eff;

  // frame difference, its square and the gap penalty
  logic [CNT_W-1:0]    gap_full;
  logic [2*FR_W+5:0]   gap_x;
  logic [2*FR_W+37:0]  gap_prod;
  assign gap_full = (rows > cols) ? rows - cols : cols - rows;
  // gap*gap*256/20 is gap*gap*64/5, taken by reciprocal multiply
  assign gap_x    = {gapsq, 6'd0};
  assign gap_prod = (2*FR_W+38)'(gap_x) * (2*FR_W+38)'(dtw_pkg::PENALTY_RECIP);

  always_ff @(posedge clk) begin
    if (cmd.gap_calc) gap <= FR_W'(gap_full);
    if (cmd.gapsq_calc) gapsq <= gap * gap;
    if (cmd.row_init) gap_quo <= dtw_pkg::DIV_W'(gap_prod[2*FR_W+37:34]);
  end

  // element distance
  logic signed [SAMPLE_W-1:0] r_s, t_s, m_s;
  logic signed [SAMPLE_W+1:0] diff;
  logic [SAMPLE_W:0]          dabs;
  logic [2*SAMPLE_W+1:0]      prod;
  logic [dtw_pkg::SUM_W-1:0]  sum;

  assign r_s  = ref_rd;
  assign t_s  = test_rd;
  assign m_s  = mean_rd;
  assign diff = (SAMPLE_W+2)'(r_s) - (SAMPLE_W+2)'(t_s) + (SAMPLE_W+2)'(m_s);
  assign dabs = (SAMPLE_W+1)'(diff[SAMPLE_W+1] ? -diff : diff);

  // square root of the distance sum
  logic                       sqrt_done;
  logic [dtw_pkg::ROOT_W-1:0] root;

  dtw_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.sqrt_go),
    .value (sum),
    .done  (sqrt_done),
    .root  (root)
  );

  // row of accumulated costs
  logic [COST_W-1:0]  row_cost  [MAX_FRAMES+1];
  logic [STEPS_W-1:0] row_steps [MAX_FRAMES+1];
  logic [COST_W-1:0]  up_c;
  logic [STEPS_W-1:0] up_s;
  logic [FR_W:0]      i, j;

  always_ff @(posedge clk) begin
    up_c <= row_cost[j[FR_W-1:0]];
    up_s <= row_steps[j[FR_W-1:0]];
  end

  // predecessor choice
  logic               diag_ok, left_ok, up_ok;
  logic [COST_W-1:0]  diag_c, left_c, best_c, new_c;
  logic [STEPS_W-1:0] diag_s, left_s, best_s, new_s;
  logic               have;
  logic [COST_W:0]    cost_sum;

  assign up_ok = (i != (FR_W+1)'(1));

  always_comb begin
    have   = 1'b0;
    best_c = '0;
    best_s = '0;
    if (diag_ok) begin
      best_c = diag_c;
      best_s = diag_s;
      have   = 1'b1;
    end
    if (left_ok && (!have || left_c < best_c)) begin
      best_c = left_c;
      best_s = left_s;
      have   = 1'b1;
    end
    if (up_ok && (!have || up_c < best_c)) begin
      best_c = up_c;
      best_s = up_s;
    end
  end

  assign cost_sum = {1'b0, best_c} + (COST_W+1)'(root);
  assign new_c = cost_sum[COST_W] ? '1 : cost_sum[COST_W-1:0];
  assign new_s = (best_s >= dtw_pkg::STEPS_MAX) ? dtw_pkg::STEPS_MAX : best_s + 1'b1;

  // cell sequencing registers
  always_ff @(posedge clk) begin
    if (cmd.row_init) begin
      i        <= (FR_W+1)'(1);
      ref_base <= '0;
    end
    if (cmd.col_init) begin
      j         <= (FR_W+1)'(1);
      test_base <= '0;
      left_ok   <= 1'b0;
      diag_ok   <= (i == (FR_W+1)'(1));
      diag_c    <= '0;
      diag_s    <= '0;
      k         <= '0;
      sum       <= '0;
    end
    if (cmd.elem_mul) prod <= dabs * dabs;
    if (cmd.elem_acc) begin
      sum <= sum + dtw_pkg::SUM_W'(prod);
      k   <= k + 1'b1;
    end
    if (cmd.cell_upd) begin
      row_cost[j[FR_W-1:0]]  <= new_c;
      row_steps[j[FR_W-1:0]] <= new_s;
      left_ok <= 1'b1;
      left_c  <= new_c;
      left_s  <= new_s;
      diag_ok <= up_ok;
      diag_c  <= up_c;
      diag_s  <= up_s;
      total   <= new_c;
      steps   <= new_s;
      if (i == (FR_W+1)'(1) && j == (FR_W+1)'(1)) first <= COST_W'(root);
      j         <= j + 1'b1;
      test_base <= test_base + CNT_W'(d_eff);
      k         <= '0;
      sum       <= '0;
      if (CNT_W'(j) == cols) begin
        i        <= i + 1'b1;
        ref_base <= ref_base + CNT_W'(d_eff);
      end
    end
  end

  // result register
  logic [dtw_pkg::SCORE_W:0] score_sum;
  assign score_sum = (dtw_pkg::SCORE_W+1)'(score_quo) + (dtw_pkg::SCORE_W+1)'(gap_quo);

  always_ff @(posedge clk) begin
    if (cmd.res_ok) begin
      result.total_cost  <= total;
      result.path_length <= steps;
      result.match_score <= score_sum[dtw_pkg::SCORE_W] ? '1
                                                        : score_sum[dtw_pkg::SCORE_W-1:0];
      result.status      <= dtw_pkg::STAT_OK;
    end else if (cmd.res_bad) begin
      result.total_cost  <= '0;
      result.path_length <= '0;
      result.match_score <= '0;
      result.status      <= stat.code;
    end
  end

  // status to the sequencer
  always_comb begin
    stat.div_done  = div_done;
    stat.sqrt_done = sqrt_done;
    stat.code      = over ? dtw_pkg::STAT_OVER : (empty ? dtw_pkg::STAT_EMPTY
                                                        : dtw_pkg::STAT_OK);
    stat.last_elem = (k == d_eff - 1'b1);
    stat.last_col  = (CNT_W'(j) == cols);
    stat.last_row  = (CNT_W'(i) == rows);
  end
endmodule

>>> sv/dtw_feature_sequence_matcher_top.sv
`timescale 1ns / 1ps
// Euclidean dynamic time warping matcher for feature vector sequences.
// Input channel: an item {action, sample_value} is taken on a clock edge with
// start high and busy low. Clear, mean, reference and test items leave busy
// low, so loads may come back to back; unknown actions are dropped.
// A compute item raises busy until its result is out.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high. Write only while no compute is running.
// Result channel: result_valid is high for exactly one cycle with the result
// struct; the receiver cannot stall, so the result must be taken then.
// A compute runs setup, a row setup for each row, rows*cols cells and then
// scoring: each cell takes a store read, square and accumulate step per
// element, then the two-bit-per-cycle square root and the cost update; the
// frame counts and the score quotient run through one 40-step divider, the
// gap penalty is a multiply. busy drops in the strobe cycle, so the next
// item can be taken while the result is shown.
// Reset clears the counts and the configuration registers; stores need none.
module dtw_feature_sequence_matcher_top #(
  parameter int MAX_FRAMES = 512,
  parameter int MAX_DIMS   = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  dtw_pkg::in_item_t          item,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [dtw_pkg::CFG_W-1:0]  cfg_data,
  output logic                       result_valid,
  output dtw_pkg::result_t           result
);
  dtw_pkg::cmd_t  cmd;
  dtw_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  dtw_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .action       (item.action),
    .stat         (stat),
    .cmd          (cmd),
    .busy         (busy),
    .result_valid (result_valid)
  );

  dtw_dp #(
    .MAX_FRAMES (MAX_FRAMES),
    .MAX_DIMS   (MAX_DIMS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );
endmodule

>>> sv/dtw_checker.sv
`timescale 1ns / 1ps
module dtw_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input dtw_pkg::in_item_t item,
  input logic              result_valid,
  input dtw_pkg::result_t  result
);
  // a compute transaction keeps the block busy
  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.action == dtw_pkg::ACT_COMPUTE |=> busy)
    else $error("compute not started");

  // results never come in adjacent cycles
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe longer than one cycle");

  // a result ends a compute
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result without a compute");

  // failed loads carry zero fields
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != dtw_pkg::STAT_OK |->
      result.total_cost == '0 && result.path_length == '0 && result.match_score == '0)
    else $error("non-ok result with nonzero fields");

  // a good result has a path
  a_ok_path: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == dtw_pkg::STAT_OK |-> result.path_length != '0)
    else $error("ok result with empty path");
endmodule

bind dtw_feature_sequence_matcher_top dtw_checker u_dtw_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .item         (item),
  .result_valid (result_valid),
  .result       (result)
);
